@@ rtl/msf_pkg.sv @@
// Shared types and constants of the multi-servo sync write framer.
package msf_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CMD_REG_WRITE = 8'h04;
   localparam logic [7:0] CMD_POS_WRITE = 8'h06;
   localparam logic [7:0] OPTION_BYTE = 8'h00;
   localparam logic [15:0] LOW_MASK = 16'h00FF;
   localparam logic [15:0] HIGH_MASK = 16'hFF00;

   localparam int CSR_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      REG_COMMAND_SELECT = 3'd0,
      REG_DATA_BYTES = 3'd1,
      REG_REGISTER_ADDRESS = 3'd2,
      REG_MOVE_TIME = 3'd3,
      REG_ENTRY_COUNT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic command_select;
      logic [1:0] data_bytes;
      logic [7:0] register_address;
      logic [15:0] move_time;
      logic [5:0] entry_count;
   } cfg_type;

   // One classified entry, ready for the byte sequencer.
   typedef struct packed {
      logic hdr;
      logic last;
      logic two;
      logic [7:0] len_byte;
      logic [7:0] cmd_byte;
      logic [7:0] servo_id;
      logic [15:0] entry_value;
      logic [7:0] trail0;
      logic [7:0] trail1;
   } job_type;

endpackage

@@ rtl/msf_req_if.sv @@
// Input channel: one servo entry per item.
interface msf_req_if;
   logic valid;
   logic ready;
   logic [7:0] servo_id;
   logic [15:0] entry_value;

   modport source (output valid, output servo_id, output entry_value, input ready);
   modport sink (input valid, input servo_id, input entry_value, output ready);
endinterface

@@ rtl/msf_rsp_if.sv @@
// Result channel: one frame byte per item.
interface msf_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] frame_byte;
   logic frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ rtl/multi_servo_sync_write_framer_unit.sv @@
// Top level of the multi-servo sync write framer: CSRs, front end, job queue, back end.
//
// Takes one servo entry per item (id and value) and sends the multi-servo sync write
// frame as a byte stream, one byte per result item. The first entry of a frame is
// preceded by length, command and a zero option byte; each entry gives id, value low
// byte and, with two data bytes configured, the high byte; the last entry is followed
// by the two trailer bytes and the additive checksum, which alone carries frame_end.
// The back-end byte sequencer sends one byte per cycle while the result channel is
// ready, so an entry gives 2 or 3 output bytes, plus 3 for the header and 3 for the
// trailer and checksum; the front end takes an entry in any cycle in which the
// two-entry job queue has room. Registers sit on the APB-style CSR port at byte
// address 4*i; they are to be written only while the block is idle.
module multi_servo_sync_write_framer_unit
   import msf_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input logic clock,
   input logic reset,
   msf_req_if.sink req,
   msf_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg_ff;
   logic csr_write;
   logic [2:0] csr_index;

   logic q_push, q_full, q_pop, q_valid;
   job_type push_job, head_job;

   // CSR block; pready tied high, writes land on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_select <= 1'b0;
         cfg_ff.data_bytes <= 2'd2;
         cfg_ff.register_address <= 8'd0;
         cfg_ff.move_time <= 16'd0;
         cfg_ff.entry_count <= 6'd1;
      end else if (csr_write) begin
         case (csr_index)
            REG_COMMAND_SELECT: cfg_ff.command_select <= csr_pwdata[0];
            REG_DATA_BYTES: cfg_ff.data_bytes <= csr_pwdata[1:0];
            REG_REGISTER_ADDRESS: cfg_ff.register_address <= csr_pwdata[7:0];
            REG_MOVE_TIME: cfg_ff.move_time <= csr_pwdata[15:0];
            REG_ENTRY_COUNT: cfg_ff.entry_count <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COMMAND_SELECT: csr_prdata = {31'd0, cfg_ff.command_select};
         REG_DATA_BYTES: csr_prdata = {30'd0, cfg_ff.data_bytes};
         REG_REGISTER_ADDRESS: csr_prdata = {24'd0, cfg_ff.register_address};
         REG_MOVE_TIME: csr_prdata = {16'd0, cfg_ff.move_time};
         REG_ENTRY_COUNT: csr_prdata = {26'd0, cfg_ff.entry_count};
         default: csr_prdata = 32'd0;
      endcase
   end

   // Front end: classifies each entry (header, last, trailer) with the current config.
   msf_front #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req),
      .cfg(cfg_ff),
      .q_full(q_full),
      .q_push(q_push),
      .q_job(push_job)
   );

   // Job queue decouples entry intake from the byte stream.
   msf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_job(push_job),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_valid),
      .head_job(head_job)
   );

   // Back end: one byte per cycle while the result channel is ready, checksum kept as bytes go out.
   msf_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_job(head_job),
      .q_pop(q_pop),
      .rsp(rsp)
   );

endmodule

@@ rtl/msf_front.sv @@
// Front end: takes entries, tracks frame position, builds jobs for the queue.
module msf_front
   import msf_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input logic clock,
   input logic reset,
   msf_req_if.sink req,
   input cfg_type cfg,
   input logic q_full,
   output logic q_push,
   output job_type q_job
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [IW-1:0] entry_index_ff, entry_index_in;
   logic [7:0] eff_count;
   logic two;
   logic last;

   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;

   always_comb begin
      eff_count = {2'b00, cfg.entry_count};
      if (eff_count == 8'd0) begin
         eff_count = 8'd1;
      end else if (eff_count > 8'(MAX_ENTRIES)) begin
         eff_count = 8'(MAX_ENTRIES);
      end
      two = (cfg.data_bytes == 2'd2);
      last = ((8'(entry_index_ff) + 8'd1) >= eff_count);

      q_job.hdr = (entry_index_ff == '0);
      q_job.last = last;
      q_job.two = two;
      q_job.len_byte = 8'd6 + (two ? 8'(eff_count * 8'd3) : 8'(eff_count * 8'd2));
      q_job.cmd_byte = cfg.command_select ? CMD_POS_WRITE : CMD_REG_WRITE;
      q_job.servo_id = req.servo_id;
      q_job.entry_value = req.entry_value;
      if (cfg.command_select) begin
         q_job.trail0 = cfg.move_time[7:0];
         q_job.trail1 = 8'((cfg.move_time & HIGH_MASK) >> 8);
      end else begin
         q_job.trail0 = cfg.register_address;
         q_job.trail1 = eff_count;
      end

      entry_index_in = entry_index_ff;
      if (q_push) begin
         entry_index_in = last ? '0 : IW'(entry_index_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_index_ff <= '0;
      end else begin
         entry_index_ff <= entry_index_in;
      end
   end

endmodule

@@ rtl/msf_queue.sv @@
// Short job queue between front and back end.
module msf_queue
   import msf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input job_type push_job,
   output logic full,
   input logic pop,
   output logic head_valid,
   output job_type head_job
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= CW'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= CW'(count_ff - 1'b1);
         end
      end
   end

endmodule

@@ rtl/msf_back.sv @@
// Back end: byte sequencer, running checksum and output register.
module msf_back
   import msf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic q_valid,
   input job_type q_job,
   output logic q_pop,
   msf_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      SLOT_LEN,
      SLOT_CMD,
      SLOT_OPT,
      SLOT_ID,
      SLOT_LO,
      SLOT_HI,
      SLOT_T0,
      SLOT_T1,
      SLOT_SUM
   } slot_type;

   slot_type slot_ff, slot_in;
   logic busy_ff, busy_in;
   job_type job_ff, job_in;
   logic [7:0] sum_ff, sum_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic out_end_ff, out_end_in;

   logic advance;
   logic done;
   logic [7:0] cur_byte;
   slot_type step_slot;

   assign rsp.valid = out_valid_ff;
   assign rsp.frame_byte = out_byte_ff;
   assign rsp.frame_end = out_end_ff;

   always_comb begin
      advance = !out_valid_ff || rsp.ready;
      done = 1'b0;
      step_slot = slot_ff;
      cur_byte = 8'd0;
      case (slot_ff)
         SLOT_LEN: begin
            cur_byte = job_ff.len_byte;
            step_slot = SLOT_CMD;
         end
         SLOT_CMD: begin
            cur_byte = job_ff.cmd_byte;
            step_slot = SLOT_OPT;
         end
         SLOT_OPT: begin
            cur_byte = OPTION_BYTE;
            step_slot = SLOT_ID;
         end
         SLOT_ID: begin
            cur_byte = job_ff.servo_id;
            step_slot = SLOT_LO;
         end
         SLOT_LO: begin
            cur_byte = 8'(job_ff.entry_value & LOW_MASK);
            if (job_ff.two) begin
               step_slot = SLOT_HI;
            end else if (job_ff.last) begin
               step_slot = SLOT_T0;
            end else begin
               done = 1'b1;
            end
         end
         SLOT_HI: begin
            cur_byte = 8'((job_ff.entry_value & HIGH_MASK) >> 8);
            if (job_ff.last) begin
               step_slot = SLOT_T0;
            end else begin
               done = 1'b1;
            end
         end
         SLOT_T0: begin
            cur_byte = job_ff.trail0;
            step_slot = SLOT_T1;
         end
         SLOT_T1: begin
            cur_byte = job_ff.trail1;
            step_slot = SLOT_SUM;
         end
         SLOT_SUM: begin
            cur_byte = sum_ff;
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase

      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_end_in = out_end_ff;
      sum_in = sum_ff;
      slot_in = slot_ff;
      busy_in = busy_ff;
      job_in = job_ff;

      if (advance) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            out_byte_in = cur_byte;
            out_end_in = (slot_ff == SLOT_SUM);
            if (slot_ff == SLOT_LEN) begin
               sum_in = cur_byte;
            end else if (slot_ff == SLOT_SUM) begin
               sum_in = 8'd0;
            end else begin
               sum_in = 8'(sum_ff + cur_byte);
            end
            slot_in = step_slot;
            if (done) begin
               busy_in = 1'b0;
            end
         end
      end

      q_pop = q_valid && (!busy_ff || (advance && done));
      if (q_pop) begin
         job_in = q_job;
         busy_in = 1'b1;
         slot_in = q_job.hdr ? SLOT_LEN : SLOT_ID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_LEN;
         busy_ff <= 1'b0;
         sum_ff <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         busy_ff <= busy_in;
         sum_ff <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff <= job_in;
      out_byte_ff <= out_byte_in;
      out_end_ff <= out_end_in;
   end

endmodule
